[design/afc_pkg.sv]
`timescale 1ns / 1ps

package afc_pkg;

	localparam int NUM_PLANES_DEF = 6;
	localparam int COORD_BITS_DEF = 16;
	localparam int PLANE_REGS     = 6;
	localparam int COEF_BITS      = 16;
	localparam int PLANE_BITS     = 4 * COEF_BITS;
	localparam int CFG_IDX_BITS   = 3;
	localparam int AXES           = 3;
	localparam int D_SHIFT        = 8;

	typedef logic [CFG_IDX_BITS-1:0] afc_idx_t;
	typedef logic [PLANE_BITS-1:0]   afc_plane_t;

	typedef struct packed {
		logic     valid;
		afc_idx_t index;
	} afc_cfg_sel_t;

endpackage

[design/afc_cfg_if.sv]
`timescale 1ns / 1ps

interface afc_cfg_if import afc_pkg::*; ();
	logic       valid;
	logic       ready;
	afc_idx_t   index;
	afc_plane_t data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[design/afc_box_if.sv]
`timescale 1ns / 1ps

interface afc_box_if import afc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] low_x;
	logic signed [COORD_BITS-1:0] low_y;
	logic signed [COORD_BITS-1:0] low_z;
	logic signed [COORD_BITS-1:0] high_x;
	logic signed [COORD_BITS-1:0] high_y;
	logic signed [COORD_BITS-1:0] high_z;

	modport source (
		output valid, output low_x, output low_y, output low_z,
		output high_x, output high_y, output high_z, input ready
	);
	modport sink (
		input valid, input low_x, input low_y, input low_z,
		input high_x, input high_y, input high_z, output ready
	);
endinterface

[design/afc_vis_if.sv]
`timescale 1ns / 1ps

interface afc_vis_if ();
	logic valid;
	logic ready;
	logic visible;

	modport source (output valid, output visible, input ready);
	modport sink (input valid, input visible, output ready);
endinterface

[design/afc_cell.sv]
`timescale 1ns / 1ps

module afc_cell import afc_pkg::*; #(
	parameter int       COORD_BITS = COORD_BITS_DEF,
	parameter afc_idx_t CELL_IDX   = '0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  afc_cfg_sel_t                cfg_sel,
	input  afc_plane_t                  cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [2*AXES*COORD_BITS-1:0] in_box,
	input  logic                        in_vis,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [2*AXES*COORD_BITS-1:0] out_box,
	output logic                        out_vis
);

	localparam int BOX_BITS = 2 * AXES * COORD_BITS;
	localparam int PW       = COEF_BITS + COORD_BITS;
	localparam int SW       = PW + 2;

	afc_plane_t plane_q;

	logic                 v_s1;
	logic [BOX_BITS-1:0]  box_s1;
	logic                 vis_s1;
	logic signed [PW-1:0] prod_lo_s1 [AXES];
	logic signed [PW-1:0] prod_hi_s1 [AXES];

	logic                 v_s2;
	logic [BOX_BITS-1:0]  box_s2;
	logic                 vis_s2;

	logic                 rdy1;
	logic                 rdy2;
	logic signed [PW-1:0] prod_lo [AXES];
	logic signed [PW-1:0] prod_hi [AXES];
	logic signed [PW-1:0] pick [AXES];
	logic signed [SW-1:0] sum;
	logic                 pass;

	assign rdy2     = !v_s2 || out_ready;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= '0;
		end else if (cfg_sel.valid && cfg_sel.index == CELL_IDX) begin
			plane_q <= cfg_data;
		end
	end

	always_comb begin
		for (int k = 0; k < AXES; k++) begin
			prod_lo[k] = $signed(plane_q[k*COEF_BITS +: COEF_BITS])
				* $signed(in_box[k*COORD_BITS +: COORD_BITS]);
			prod_hi[k] = $signed(plane_q[k*COEF_BITS +: COEF_BITS])
				* $signed(in_box[(AXES+k)*COORD_BITS +: COORD_BITS]);
		end
	end

	always_comb begin
		sum = SW'($signed({plane_q[PLANE_BITS-1 -: COEF_BITS], {D_SHIFT{1'b0}}}));
		for (int k = 0; k < AXES; k++) begin
			pick[k] = (prod_lo_s1[k] > prod_hi_s1[k]) ? prod_lo_s1[k] : prod_hi_s1[k];
			sum     = sum + SW'(pick[k]);
		end
		pass = !sum[SW-1] && (|sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= in_valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			box_s1 <= in_box;
			vis_s1 <= in_vis;
			for (int k = 0; k < AXES; k++) begin
				prod_lo_s1[k] <= prod_lo[k];
				prod_hi_s1[k] <= prod_hi[k];
			end
		end
		if (rdy2 && v_s1) begin
			box_s2 <= box_s1;
			vis_s2 <= vis_s1 && pass;
		end
	end

	assign out_valid = v_s2;
	assign out_box   = box_s2;
	assign out_vis   = vis_s2;

`ifndef SYNTHESIS
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v_s1 && v_s2)
		else $error("cell refuses a transaction with a free stage");
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		rdy2 && v_s1 |=> v_s2)
		else $error("cell lost a transaction between stages");
	a_culled_stays: assert property (@(posedge clk) disable iff (!arst_n)
		rdy2 && v_s1 && !vis_s1 |=> !vis_s2)
		else $error("culled box became visible");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !out_ready |=> v_s2 && $stable(vis_s2))
		else $error("stalled cell output changed");
`endif

endmodule

[design/aabb_frustum_cull_test.sv]
`timescale 1ns / 1ps
// box frustum culling against up to six planes
// cfg: write transactions load plane registers; index 0..5 selects the plane,
//   data packs a (15:0), b (31:16), c (47:32), d (63:48), each signed Q8.8;
//   indexes beyond the plane list are ignored; cfg.ready is always high
// box: one axis-aligned box per transaction, low and high corners, signed Q8.8
// result: one transaction per box, visible = 1 when every plane sees some
//   corner strictly in front of it, 0 when the box is culled
// the boxes flow through a row of NUM_PLANES cells, one cell per plane, each
//   two registers deep (products, then sum and compare)
// throughput: one box per cycle, every cell stage takes a new box each cycle
//   unless it is full and the stage after it is held
// reset clears all planes to zero, so every box is culled until planes are
//   written, and empties the row
// when the receiver stalls the last cell holds its result; earlier cells keep
//   filling empty slots, and box.ready drops only when the whole row is full
module aabb_frustum_cull_test import afc_pkg::*; #(
	parameter int NUM_PLANES = NUM_PLANES_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	afc_cfg_if.sink     cfg,
	afc_box_if.sink     box,
	afc_vis_if.source   result
);

	localparam int BOX_BITS = 2 * AXES * COORD_BITS;

	logic                valid_c [NUM_PLANES+1];
	logic                ready_c [NUM_PLANES+1];
	logic [BOX_BITS-1:0] box_c   [NUM_PLANES+1];
	logic                vis_c   [NUM_PLANES+1];
	afc_cfg_sel_t        cfg_sel;

	assign cfg.ready     = 1'b1;
	assign cfg_sel.valid = cfg.valid;
	assign cfg_sel.index = cfg.index;

	assign valid_c[0] = box.valid;
	assign box.ready  = ready_c[0];
	assign box_c[0]   = {box.high_z, box.high_y, box.high_x, box.low_z, box.low_y, box.low_x};
	assign vis_c[0]   = 1'b1;

	for (genvar i = 0; i < NUM_PLANES; i++) begin : g_cell
		afc_cell #(
			.COORD_BITS (COORD_BITS),
			.CELL_IDX   (afc_idx_t'(i))
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cfg_sel   (cfg_sel),
			.cfg_data  (cfg.data),
			.in_valid  (valid_c[i]),
			.in_ready  (ready_c[i]),
			.in_box    (box_c[i]),
			.in_vis    (vis_c[i]),
			.out_valid (valid_c[i+1]),
			.out_ready (ready_c[i+1]),
			.out_box   (box_c[i+1]),
			.out_vis   (vis_c[i+1])
		);
	end

	assign result.valid       = valid_c[NUM_PLANES];
	assign result.visible     = vis_c[NUM_PLANES];
	assign ready_c[NUM_PLANES] = result.ready;

	logic unused_box;
	assign unused_box = ^box_c[NUM_PLANES];

endmodule

[test/afc_cull_checker.sv]
`timescale 1ns / 1ps

module afc_cull_checker import afc_pkg::*; #(
	parameter int NUM_PLANES = NUM_PLANES_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	afc_cfg_if   cfg,
	afc_box_if   box,
	afc_vis_if   result,
	output int   fails,
	output int   in_flight
);

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef coord_t corner_t [AXES];
	typedef afc_plane_t plane_set_t [PLANE_REGS];

	plane_set_t planes;
	bit         vis_due [$];

	function automatic longint coef_at(input afc_plane_t pl, input int slot);
		return longint'($signed(pl[slot*COEF_BITS +: COEF_BITS]));
	endfunction

	// per axis take the corner that lies furthest in front of the plane
	function automatic bit box_in_view(input plane_set_t pl, input corner_t lo, input corner_t hi);
		longint reach;
		longint lo_term;
		longint hi_term;
		bit     seen;
		seen = 1'b1;
		for (int p = 0; p < NUM_PLANES && p < PLANE_REGS; p++) begin
			reach = coef_at(pl[p], AXES) * (longint'(1) << D_SHIFT);
			for (int ax = 0; ax < AXES; ax++) begin
				lo_term = coef_at(pl[p], ax) * longint'(lo[ax]);
				hi_term = coef_at(pl[p], ax) * longint'(hi[ax]);
				reach += (lo_term > hi_term) ? lo_term : hi_term;
			end
			if (reach <= 0)
				seen = 1'b0;
		end
		return seen;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		corner_t lo;
		corner_t hi;
		bit      want;
		if (!arst_n) begin
			foreach (planes[i])
				planes[i] = '0;
			vis_due.delete();
			fails <= 0;
			in_flight <= 0;
		end else begin
			if (cfg.valid && cfg.ready && cfg.index < PLANE_REGS)
				planes[cfg.index] = cfg.data;
			if (result.valid && result.ready) begin
				if (vis_due.size() == 0) begin
					$display("%0t: result transaction with none expected, visible %b",
						$time, result.visible);
					fails <= fails + 1;
				end else begin
					want = vis_due.pop_front();
					if (result.visible !== want) begin
						$display("%0t: visible mismatch, expected %b, actual %b",
							$time, want, result.visible);
						fails <= fails + 1;
					end
				end
			end
			if (box.valid && box.ready) begin
				lo = '{box.low_x, box.low_y, box.low_z};
				hi = '{box.high_x, box.high_y, box.high_z};
				vis_due.insert(vis_due.size(), box_in_view(planes, lo, hi));
			end
			in_flight <= vis_due.size();
		end
	end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import afc_pkg::*;

	typedef logic signed [COORD_BITS_DEF-1:0] coord_t;
	typedef afc_plane_t plane_set_t [PLANE_REGS];

	localparam coord_t C_MIN       = 16'sh8000;
	localparam coord_t C_MAX       = 16'sh7fff;
	localparam coord_t ONE         = 16'sh0100;
	localparam coord_t ZERO        = 16'sh0000;
	localparam int     RAND_PHASES = 8;
	localparam int     PHASE_BOXES = 82;
	localparam int     SETTLE      = 4 * NUM_PLANES_DEF;

	logic clk = 1'b0;
	logic arst_n;
	int   fails;
	int   in_flight;
	int   gap_odds = 0;
	int   stall_odds = 0;

	afc_cfg_if cfg ();
	afc_box_if #(.COORD_BITS(COORD_BITS_DEF)) box ();
	afc_vis_if result ();

	aabb_frustum_cull_test #(
		.NUM_PLANES(NUM_PLANES_DEF),
		.COORD_BITS(COORD_BITS_DEF)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.box(box),
		.result(result)
	);

	afc_cull_checker #(
		.NUM_PLANES(NUM_PLANES_DEF),
		.COORD_BITS(COORD_BITS_DEF)
	) vis_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.box(box),
		.result(result),
		.fails(fails),
		.in_flight(in_flight)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	// receiver stalls in bursts
	initial begin
		result.ready <= 1'b1;
		forever begin
			@(posedge clk);
			if ($urandom_range(1, 100) <= stall_odds) begin
				result.ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			result.ready <= 1'b1;
		end
	end

	function automatic afc_plane_t pack_plane(input coord_t a, b, c, d);
		return {d, c, b, a};
	endfunction

	function automatic coord_t any_coord();
		return coord_t'($urandom_range(0, 16'hffff));
	endfunction

	function automatic coord_t rim_coord();
		case ($urandom_range(0, 4))
			0: return C_MIN;
			1: return C_MAX;
			2: return -coord_t'(1);
			3: return coord_t'(1);
			default: return ZERO;
		endcase
	endfunction

	task automatic send_box(input coord_t lx, ly, lz, hx, hy, hz);
		if ($urandom_range(1, 100) <= gap_odds) begin
			box.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		box.valid  <= 1'b1;
		box.low_x  <= lx;
		box.low_y  <= ly;
		box.low_z  <= lz;
		box.high_x <= hx;
		box.high_y <= hy;
		box.high_z <= hz;
		do @(posedge clk); while (!box.ready);
	endtask

	// the two indexes past the plane list must be ignored
	task automatic program_planes(input plane_set_t pl);
		for (int i = 0; i < PLANE_REGS + 2; i++) begin
			cfg.valid <= 1'b1;
			cfg.index <= afc_idx_t'(i);
			cfg.data  <= (i < PLANE_REGS) ? pl[i] : {$urandom, $urandom};
			do @(posedge clk); while (!cfg.ready);
		end
		cfg.valid <= 1'b0;
	endtask

	task automatic drain();
		box.valid <= 1'b0;
		@(posedge clk);
		while (in_flight != 0)
			@(posedge clk);
	endtask

	task automatic random_planes(input int kind, output plane_set_t pl);
		foreach (pl[i]) begin
			case (kind)
				0: pl[i] = {$urandom, $urandom};
				1: pl[i] = pack_plane(coord_t'($urandom_range(0, 1024) - 512),
					coord_t'($urandom_range(0, 1024) - 512),
					coord_t'($urandom_range(0, 1024) - 512),
					coord_t'($urandom_range(0, 2304) - 256));
				default: pl[i] = pack_plane(rim_coord(), rim_coord(), rim_coord(), rim_coord());
			endcase
		end
	endtask

	// mostly well-formed boxes near the origin, some swapped, some raw noise, some at the rim values
	task automatic random_box();
		coord_t lo [AXES];
		coord_t hi [AXES];
		int     mode;
		int     mid;
		int     half;
		mode = $urandom_range(0, 9);
		for (int ax = 0; ax < AXES; ax++) begin
			if (mode < 7) begin
				mid = $urandom_range(0, 2048) - 1024;
				half = $urandom_range(0, 512);
				lo[ax] = coord_t'((mode == 6) ? mid + half : mid - half);
				hi[ax] = coord_t'((mode == 6) ? mid - half : mid + half);
			end else if (mode < 9) begin
				lo[ax] = any_coord();
				hi[ax] = any_coord();
			end else begin
				lo[ax] = rim_coord();
				hi[ax] = rim_coord();
			end
		end
		send_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
	endtask

	initial begin
		plane_set_t pl;
		arst_n     <= 1'b0;
		box.valid  <= 1'b0;
		box.low_x  <= '0;
		box.low_y  <= '0;
		box.low_z  <= '0;
		box.high_x <= '0;
		box.high_y <= '0;
		box.high_z <= '0;
		cfg.valid  <= 1'b0;
		cfg.index  <= '0;
		cfg.data   <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// planes still zero after reset, so everything is culled
		send_box(ZERO, ZERO, ZERO, ZERO, ZERO, ZERO);
		send_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
		send_box(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN);
		drain();

		// unit cube frustum
		gap_odds = 30;
		stall_odds = 30;
		pl = '{pack_plane(ONE, ZERO, ZERO, ONE), pack_plane(-ONE, ZERO, ZERO, ONE),
			pack_plane(ZERO, ONE, ZERO, ONE), pack_plane(ZERO, -ONE, ZERO, ONE),
			pack_plane(ZERO, ZERO, ONE, ONE), pack_plane(ZERO, ZERO, -ONE, ONE)};
		program_planes(pl);
		send_box(ZERO, ZERO, ZERO, ZERO, ZERO, ZERO);
		send_box(-16'sd128, -16'sd128, -16'sd128, 16'sd128, 16'sd128, 16'sd128);
		send_box(16'sd512, ZERO, ZERO, 16'sd768, ZERO, ZERO);
		send_box(-16'sd512, ZERO, ZERO, ZERO, ZERO, ZERO);
		send_box(16'sd512, ZERO, ZERO, -16'sd512, ZERO, ZERO);
		send_box(-ONE, ZERO, ZERO, -ONE, ZERO, ZERO);
		send_box(-16'sd255, ZERO, ZERO, -16'sd255, ZERO, ZERO);
		send_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
		send_box(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
		send_box(C_MIN, ZERO, ZERO, C_MIN, ZERO, ZERO);
		drain();

		// extreme coefficients
		pl = '{pack_plane(C_MAX, C_MIN, C_MAX, C_MIN), pack_plane(C_MIN, C_MAX, C_MIN, C_MAX),
			pack_plane(C_MIN, C_MIN, C_MIN, C_MIN), pack_plane(C_MAX, C_MAX, C_MAX, C_MAX),
			pack_plane(ZERO, ZERO, ZERO, C_MAX), pack_plane(coord_t'(1), -coord_t'(1), ZERO,
			-coord_t'(1))};
		program_planes(pl);
		send_box(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
		send_box(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
		send_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
		send_box(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN);
		send_box(C_MAX, C_MIN, ZERO, C_MIN, C_MAX, ZERO);
		send_box(ZERO, ZERO, ZERO, ZERO, ZERO, ZERO);
		drain();

		for (int p = 0; p < RAND_PHASES; p++) begin
			if (p == RAND_PHASES - 1) begin
				gap_odds = 0;
				stall_odds = 0;
			end else begin
				gap_odds = $urandom_range(0, 2) * 25;
				stall_odds = $urandom_range(0, 2) * 25;
			end
			random_planes((p % 2 == 0) ? 1 : ((p % 4 == 1) ? 0 : 2), pl);
			program_planes(pl);
			repeat (PHASE_BOXES)
				random_box();
			drain();
		end

		repeat (SETTLE) @(posedge clk);
		if (fails == 0 && in_flight == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
